// File: rtl/blqs_pkg.sv
// blqs_pkg: shared constants, codes and controller/datapath types
`default_nettype none

package blqs_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [ModeW-1:0] ModeList  = 2'd0;
  localparam logic [ModeW-1:0] ModeQueue = 2'd1;

  localparam logic ActInsert = 1'b0;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_I      = 2'd0,
    RD_I_NEXT = 2'd1,
    RD_J_PREV = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_TAIL_VAL = 2'd0,
    WR_I_DATA   = 2'd1,
    WR_J_DATA   = 2'd2,
    WR_J_KEY    = 2'd3
  } wr_sel_e;

  typedef enum logic [1:0] {
    I_ZERO = 2'd0,
    I_LAST = 2'd1,
    I_SORT = 2'd2
  } i_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    set_status;
    status_e status;
    logic    i_load;
    i_sel_e  i_sel;
    logic    i_inc;
    logic    j_load;
    logic    j_dec;
    logic    key_load;
    logic    removed_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    count_dec;
    logic    set_sorted;
    logic    result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic             act;
    logic [ModeW-1:0] mode;
    logic             empty;
    logic             full;
    logic             eq;
    logic             gt;
    logic             i_lt_cnt;
    logic             i_is_last;
    logic             i_next_lt_cnt;
    logic             j_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/blqs_if.sv
// blqs_if: valid/ready channel interfaces for commands, results and configuration
`default_nettype none

interface blqs_item_if;
  import blqs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [DataW-1:0] value;
  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface blqs_result_if;
  import blqs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [CountW-1:0]       count;
  logic signed [DataW-1:0] removed_value;
  modport source (output valid, status, count, removed_value, input ready);
  modport sink (input valid, status, count, removed_value, output ready);
endinterface

interface blqs_cfg_if;
  import blqs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

`default_nettype wire

// File: rtl/bounded_list_queue_stack_top.sv
// bounded_list_queue_stack_top: sorted list / queue / stack of signed words
`default_nettype none

// Holds up to Depth signed 32-bit words in a single-port-read memory and
// handles one command at a time. Each command yields one result with status,
// new count and the removed word. A refused command or a queue/stack insert
// goes straight to the result. A queue/stack remove takes the front or last
// entry and a found list remove probes entries up to its word; both then move
// any later entries down. A list remove that finds nothing probes every held
// entry. A list insert into an ordered store moves each entry greater than
// the new word up by one; a list insert after queue or stack writes reorders
// the whole store. Each step makes at most one memory access and one compare.
// The next command is taken while the previous result still waits in the
// output register.
module bounded_list_queue_stack_top import blqs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  blqs_item_if.sink     in_if,
  blqs_result_if.source out_if,
  blqs_cfg_if.sink      cfg_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  res_status;

  assign cfg_if.ready = 1'b1;

  blqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  blqs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_if.valid),
    .cfg_mode_i    (cfg_if.mode),
    .in_action_i   (in_if.action),
    .in_value_i    (in_if.value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .res_status_o  (res_status),
    .res_count_o   (out_if.count),
    .res_removed_o (out_if.removed_value)
  );

  assign out_if.status = res_status;

endmodule

`default_nettype wire

// File: rtl/blqs_datapath.sv
// blqs_datapath: entry memory, count, indexes, key and result registers
`default_nettype none

module blqs_datapath import blqs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ModeW-1:0]        cfg_mode_i,
  input  logic                    in_action_i,
  input  logic signed [DataW-1:0] in_value_i,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  output status_e                 res_status_o,
  output logic [CountW-1:0]       res_count_o,
  output logic signed [DataW-1:0] res_removed_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  logic [ModeW-1:0] mode_q;
  logic [CntW-1:0]  count_q;
  logic             sorted_q;

  logic             act_q;
  logic [DataW-1:0] val_q;
  logic [DataW-1:0] key_q;
  logic [DataW-1:0] removed_q;
  status_e          status_q;
  logic [CntW-1:0]  i_q;
  logic [AddrW-1:0] j_q;

  status_e          res_status_q;
  logic [CountW-1:0] res_count_q;
  logic [DataW-1:0] res_removed_q;

  logic [CntW:0]    i_next;
  logic [CntW:0]    count_ext;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] wr_data;
  logic [CntW-1:0]  i_init;

  assign i_next    = {1'b0, i_q} + (CntW + 1)'(1);
  assign count_ext = {1'b0, count_q};

  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:      rd_addr = i_q[AddrW-1:0];
      RD_I_NEXT: rd_addr = i_next[AddrW-1:0];
      RD_J_PREV: rd_addr = j_q - AddrW'(1);
      default:   rd_addr = i_q[AddrW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_TAIL_VAL: begin
        wr_addr = count_q[AddrW-1:0];
        wr_data = val_q;
      end
      WR_I_DATA: begin
        wr_addr = i_q[AddrW-1:0];
        wr_data = rd_data_q;
      end
      WR_J_DATA: begin
        wr_addr = j_q;
        wr_data = rd_data_q;
      end
      WR_J_KEY: begin
        wr_addr = j_q;
        wr_data = key_q;
      end
      default: begin
        wr_addr = j_q;
        wr_data = key_q;
      end
    endcase
  end

  // sort start: a sorted store only needs the new tail placed
  always_comb begin
    case (cmd_i.i_sel)
      I_ZERO:  i_init = '0;
      I_LAST:  i_init = count_q - CntW'(1);
      I_SORT:  i_init = sorted_q ? count_q : CntW'(1);
      default: i_init = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeList;
      count_q  <= '0;
      sorted_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (cmd_i.push) begin
        count_q <= count_q + CntW'(1);
        if (mode_q != ModeList) begin
          sorted_q <= 1'b0;
        end
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.set_sorted) begin
        sorted_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q     <= in_action_i;
      val_q     <= in_value_i;
      status_q  <= ST_DONE;
      removed_q <= '0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.removed_load) begin
        removed_q <= rd_data_q;
      end
    end
    if (cmd_i.i_load) begin
      i_q <= i_init;
    end else if (cmd_i.i_inc) begin
      i_q <= i_next[CntW-1:0];
    end
    if (cmd_i.j_load) begin
      j_q <= i_q[AddrW-1:0];
    end else if (cmd_i.j_dec) begin
      j_q <= j_q - AddrW'(1);
    end
    if (cmd_i.key_load) begin
      key_q <= rd_data_q;
    end
    if (cmd_i.result_load) begin
      res_status_q  <= status_q;
      res_count_q   <= CountW'(count_q);
      res_removed_q <= removed_q;
    end
  end

  always_comb begin
    stat_o.act           = act_q;
    stat_o.mode          = mode_q;
    stat_o.empty         = (count_q == '0);
    stat_o.full          = (count_q == CntW'(Depth));
    stat_o.eq            = (rd_data_q == val_q);
    stat_o.gt            = ($signed(rd_data_q) > $signed(key_q));
    stat_o.i_lt_cnt      = (i_q < count_q);
    stat_o.i_is_last     = (i_next == count_ext);
    stat_o.i_next_lt_cnt = (i_next < count_ext);
    stat_o.j_zero        = (j_q == '0);
  end

  assign res_status_o  = res_status_q;
  assign res_count_o   = res_count_q;
  assign res_removed_o = $signed(res_removed_q);

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CntW'(Depth)))
    else $error("push into a full store");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("count did not follow push");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_dec |-> (count_q != '0))
    else $error("take from an empty store");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (CntW'(rd_addr) < count_q))
    else $error("read beyond held entries");

  a_sort_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_sorted |-> (mode_q == ModeList))
    else $error("sort finished outside list mode");

endmodule

`default_nettype wire

// File: rtl/blqs_ctrl.sv
// blqs_ctrl: operation sequencer and result valid flag
`default_nettype none

module blqs_ctrl import blqs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE        = 12'b0000_0000_0001,
    S_DECIDE      = 12'b0000_0000_0010,
    S_SRCH_RD     = 12'b0000_0000_0100,
    S_SRCH_CMP    = 12'b0000_0000_1000,
    S_SHIFT_RD    = 12'b0000_0001_0000,
    S_SHIFT_WR    = 12'b0000_0010_0000,
    S_SORT_CHK    = 12'b0000_0100_0000,
    S_SORT_KEY_RD = 12'b0000_1000_0000,
    S_SORT_KEY    = 12'b0001_0000_0000,
    S_SORT_CMP_RD = 12'b0010_0000_0000,
    S_SORT_CMP    = 12'b0100_0000_0000,
    S_FINISH      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.act == ActInsert) begin
          if (stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status = ST_FULL;
            state_d = S_FINISH;
          end else begin
            cmd_o.push = 1'b1;
            cmd_o.wr_en = 1'b1;
            cmd_o.wr_sel = WR_TAIL_VAL;
            if (stat_i.mode == ModeList) begin
              cmd_o.i_load = 1'b1;
              cmd_o.i_sel = I_SORT;
              state_d = S_SORT_CHK;
            end else begin
              state_d = S_FINISH;
            end
          end
        end else if (stat_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = ST_EMPTY;
          state_d = S_FINISH;
        end else begin
          cmd_o.i_load = 1'b1;
          cmd_o.i_sel = (stat_i.mode inside {ModeList, ModeQueue}) ? I_ZERO : I_LAST;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_I;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat_i.mode != ModeList || stat_i.eq) begin
          cmd_o.removed_load = 1'b1;
          state_d = S_SHIFT_RD;
        end else if (stat_i.i_is_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = ST_NOTFOUND;
          state_d = S_FINISH;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.i_next_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_I_NEXT;
          state_d = S_SHIFT_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_sel = WR_I_DATA;
        cmd_o.i_inc = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_SORT_CHK: begin
        if (stat_i.i_lt_cnt) begin
          state_d = S_SORT_KEY_RD;
        end else begin
          cmd_o.set_sorted = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_SORT_KEY_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_I;
        state_d = S_SORT_KEY;
      end
      S_SORT_KEY: begin
        cmd_o.key_load = 1'b1;
        cmd_o.j_load = 1'b1;
        state_d = S_SORT_CMP_RD;
      end
      S_SORT_CMP_RD: begin
        if (stat_i.j_zero) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel = WR_J_KEY;
          cmd_o.i_inc = 1'b1;
          state_d = S_SORT_CHK;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_J_PREV;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.gt) begin
          cmd_o.wr_sel = WR_J_DATA;
          cmd_o.j_dec = 1'b1;
          state_d = S_SORT_CMP_RD;
        end else begin
          cmd_o.wr_sel = WR_J_KEY;
          cmd_o.i_inc = 1'b1;
          state_d = S_SORT_CHK;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.result_load;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.result_load)
    else $error("result overwritten before transfer");

  a_one_mem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (cmd_o.wr_en && cmd_o.wr_sel == WR_TAIL_VAL && !cmd_o.count_dec))
    else $error("push without tail write");

  a_accept_then_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECIDE))
    else $error("accepted command not decoded");

endmodule

`default_nettype wire
